// File: rtl/core/npsnap_pkg.sv
// Package for the nearest point snap block: sizes, word types and the
// controller states. Depends on nothing; every other file uses it.
package npsnap_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int COORD_BITS = 24;

	localparam int ADDR_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W   = ADDR_W + 1;
	localparam int MAG_W   = COORD_BITS + 1;
	localparam int PROD_W  = 2 * MAG_W;
	localparam int DIST_W  = 50;
	localparam int SUM_W   = DIST_W + 2;
	localparam int COUNT_W = 11;
	localparam int SLOT_W  = 10;
	localparam int INDEX_W = 10;
	localparam int ENTRY_W = 3 * COORD_BITS;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [MAG_W-1:0] mag_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic {
		REG_POINT_COUNT = 1'b0,
		REG_UNUSED      = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic              opcode;
		logic [SLOT_W-1:0] slot;
		coord_t            coord_x;
		coord_t            coord_y;
		coord_t            coord_z;
		logic              batch_start;
	} cmd_word_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] nearest_index;
		coord_t             snap_x;
		coord_t             snap_y;
		coord_t             snap_z;
		dist_t              dist_squared;
		dist_t              max_move_squared;
	} res_word_t;

	// Absolute difference of two coordinates, one bit wider than a coordinate.
	function automatic mag_t abs_diff(input coord_t a, input coord_t b);
		logic signed [MAG_W-1:0] d;
		d = MAG_W'(a) - MAG_W'(b);
		return (d < 0) ? mag_t'(-d) : mag_t'(d);
	endfunction

	// Square already formed; saturate it to the distance width.
	function automatic dist_t sat_sq(input logic [PROD_W-1:0] p);
		logic [PROD_W+DIST_W-1:0] pw;
		logic [PROD_W+DIST_W-1:0] lim;
		pw  = {{DIST_W{1'b0}}, p};
		lim = {{PROD_W{1'b0}}, DIST_MAX};
		return (pw > lim) ? DIST_MAX : pw[DIST_W-1:0];
	endfunction

	function automatic dist_t sat_sum3(input dist_t a, input dist_t b, input dist_t c);
		logic [SUM_W-1:0] s;
		s = SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
		return (s > SUM_W'(DIST_MAX)) ? DIST_MAX : s[DIST_W-1:0];
	endfunction

endpackage

// File: rtl/core/npsnap_if.sv
// Valid/ready channel interfaces for the command and result words.
// Depends on npsnap_pkg for the word types.
interface npsnap_cmd_if;
	logic                  valid;
	logic                  ready;
	npsnap_pkg::cmd_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface npsnap_res_if;
	logic                  valid;
	logic                  ready;
	npsnap_pkg::res_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/nearest_point_snap_3d.sv
// Nearest point snap: reference store, scan pipeline and result register.
// Depends on npsnap_pkg and the channel interfaces in npsnap_if.sv.
//
// A load word writes one point into the store. A query word scans the first
// point_count stored points (at most MAX_POINTS), reading one entry a cycle from
// the store's single read port. After a query word the command port stays closed
// while each point is read, the store read and the three arithmetic stages drain,
// the pipeline is seen empty and the result moves into the output register. A
// query with nothing to search also closes it while it passes the scan and done
// states. The result word waits in the output register, and load words are taken
// meanwhile; a further query may start but cannot finish until the waiting result
// has been taken, and it is held in its done state until then. The store needs no
// clearing after reset.
module nearest_point_snap_3d (
	input  logic                                clk,
	input  logic                                arst_n,
	npsnap_cmd_if.sink                          cmd,
	npsnap_res_if.source                        res,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [npsnap_pkg::PADDR_W-1:0]      paddr,
	input  logic [npsnap_pkg::PDATA_W-1:0]      pwdata,
	output logic [npsnap_pkg::PDATA_W-1:0]      prdata,
	output logic                                pready
);

	localparam int AW = npsnap_pkg::ADDR_W;
	localparam int CW = npsnap_pkg::CNT_W;
	localparam int EW = npsnap_pkg::ENTRY_W;
	localparam int KB = npsnap_pkg::COORD_BITS;

	logic [EW-1:0] store_mem [npsnap_pkg::MAX_POINTS];

	npsnap_pkg::st_t state_q, state_d;

	logic [npsnap_pkg::COUNT_W-1:0] point_count_q;
	npsnap_pkg::dist_t              max_q;
	logic [CW-1:0]                  cnt_q;
	logic [CW-1:0]                  n_q;
	npsnap_pkg::coord_t             qx_q, qy_q, qz_q;

	logic          rd_v_s1, v_s2, v_s3, v_s4;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic [EW-1:0] ent_s1, ent_s2, ent_s3, ent_s4;
	npsnap_pkg::mag_t  mx_s2, my_s2, mz_s2;
	npsnap_pkg::dist_t sx_s3, sy_s3, sz_s3;
	npsnap_pkg::dist_t d_s4;

	logic              any_q;
	logic [AW-1:0]     best_idx_q;
	logic [EW-1:0]     best_ent_q;
	npsnap_pkg::dist_t best_d_q;

	logic              out_v_q;
	npsnap_pkg::res_word_t out_q;

	logic cmd_fire, load_fire, query_fire, cfg_wr;
	logic issue, scan_end, fin, pipe_busy;
	npsnap_pkg::dist_t new_max;
	logic [CW-1:0] n_lim;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign prdata    = (npsnap_pkg::reg_idx_t'(paddr[2]) == npsnap_pkg::REG_POINT_COUNT) ?
		npsnap_pkg::PDATA_W'(point_count_q) : '0;

	assign cmd_fire   = cmd.valid && cmd.ready;
	assign load_fire  = cmd_fire && (npsnap_pkg::op_t'(cmd.data.opcode) == npsnap_pkg::OP_LOAD);
	assign query_fire = cmd_fire && (npsnap_pkg::op_t'(cmd.data.opcode) == npsnap_pkg::OP_QUERY);
	assign pipe_busy  = rd_v_s1 || v_s2 || v_s3 || v_s4;
	assign n_lim      = (32'(point_count_q) > 32'(npsnap_pkg::MAX_POINTS)) ?
		CW'(npsnap_pkg::MAX_POINTS) : CW'(point_count_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			npsnap_pkg::ST_IDLE: if (query_fire) state_d = npsnap_pkg::ST_SCAN;
			npsnap_pkg::ST_SCAN: if (scan_end) state_d = npsnap_pkg::ST_DONE;
			npsnap_pkg::ST_DONE: if (fin) state_d = npsnap_pkg::ST_IDLE;
			default: state_d = npsnap_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready = (state_q == npsnap_pkg::ST_IDLE);
		issue     = (state_q == npsnap_pkg::ST_SCAN) && (cnt_q != n_q);
		scan_end  = (state_q == npsnap_pkg::ST_SCAN) && (cnt_q == n_q) && !pipe_busy;
		fin       = (state_q == npsnap_pkg::ST_DONE) && (!out_v_q || res.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= npsnap_pkg::ST_IDLE;
			point_count_q <= '0;
			max_q         <= '0;
			rd_v_s1       <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			v_s4          <= 1'b0;
			any_q         <= 1'b0;
			out_v_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr && npsnap_pkg::reg_idx_t'(paddr[2]) == npsnap_pkg::REG_POINT_COUNT) begin
				point_count_q <= pwdata[npsnap_pkg::COUNT_W-1:0];
			end
			if (query_fire && cmd.data.batch_start) begin
				max_q <= '0;
			end else if (fin) begin
				max_q <= new_max;
			end
			rd_v_s1 <= issue;
			v_s2    <= rd_v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			if (query_fire) begin
				any_q <= 1'b0;
			end else if (v_s4) begin
				any_q <= 1'b1;
			end
			if (fin) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Reference store: one write port for loads, one registered read port for scans.
	always_ff @(posedge clk) begin
		if (load_fire && 32'(cmd.data.slot) < 32'(npsnap_pkg::MAX_POINTS)) begin
			store_mem[AW'(cmd.data.slot)] <= {cmd.data.coord_x, cmd.data.coord_y, cmd.data.coord_z};
		end
		if (issue) begin
			ent_s1 <= store_mem[cnt_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (query_fire) begin
			qx_q  <= cmd.data.coord_x;
			qy_q  <= cmd.data.coord_y;
			qz_q  <= cmd.data.coord_z;
			n_q   <= n_lim;
			cnt_q <= '0;
		end else if (issue) begin
			cnt_q <= cnt_q + CW'(1);
		end
		idx_s1 <= cnt_q[AW-1:0];

		idx_s2 <= idx_s1;
		ent_s2 <= ent_s1;
		mx_s2  <= npsnap_pkg::abs_diff(qx_q, ent_s1[3*KB-1:2*KB]);
		my_s2  <= npsnap_pkg::abs_diff(qy_q, ent_s1[2*KB-1:KB]);
		mz_s2  <= npsnap_pkg::abs_diff(qz_q, ent_s1[KB-1:0]);

		idx_s3 <= idx_s2;
		ent_s3 <= ent_s2;
		sx_s3  <= npsnap_pkg::sat_sq(npsnap_pkg::PROD_W'(mx_s2) * npsnap_pkg::PROD_W'(mx_s2));
		sy_s3  <= npsnap_pkg::sat_sq(npsnap_pkg::PROD_W'(my_s2) * npsnap_pkg::PROD_W'(my_s2));
		sz_s3  <= npsnap_pkg::sat_sq(npsnap_pkg::PROD_W'(mz_s2) * npsnap_pkg::PROD_W'(mz_s2));

		idx_s4 <= idx_s3;
		ent_s4 <= ent_s3;
		d_s4   <= npsnap_pkg::sat_sum3(sx_s3, sy_s3, sz_s3);

		if (v_s4 && (!any_q || d_s4 < best_d_q)) begin
			best_idx_q <= idx_s4;
			best_ent_q <= ent_s4;
			best_d_q   <= d_s4;
		end
	end

	assign new_max = (any_q && best_d_q > max_q) ? best_d_q : max_q;

	always_ff @(posedge clk) begin
		if (fin) begin
			out_q.found            <= any_q;
			out_q.nearest_index    <= any_q ? npsnap_pkg::INDEX_W'(best_idx_q) : '0;
			out_q.snap_x           <= any_q ? best_ent_q[3*KB-1:2*KB] : '0;
			out_q.snap_y           <= any_q ? best_ent_q[2*KB-1:KB] : '0;
			out_q.snap_z           <= any_q ? best_ent_q[KB-1:0] : '0;
			out_q.dist_squared     <= any_q ? best_d_q : '0;
			out_q.max_move_squared <= new_max;
		end
	end

	assign res.valid = out_v_q;
	assign res.data  = out_q;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for nearest_point_snap_3d: loads reference points, runs
// queries under random source bursts and sink stalls, and checks every result word.
// Depends on npsnap_pkg and the channel interfaces in npsnap_if.sv.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int END_CYCLES     = npsnap_pkg::MAX_POINTS + 16;
	localparam int SRC_STREAM     = 0;
	localparam int SRC_BURSTY     = 1;
	localparam int SINK_READY     = 0;
	localparam int SINK_LIGHT     = 1;
	localparam int SINK_HEAVY     = 2;
	localparam npsnap_pkg::coord_t C_MIN  = {1'b1, {(npsnap_pkg::COORD_BITS-1){1'b0}}};
	localparam npsnap_pkg::coord_t C_MAX  = {1'b0, {(npsnap_pkg::COORD_BITS-1){1'b1}}};
	localparam npsnap_pkg::coord_t C_ZERO = '0;
	localparam npsnap_pkg::coord_t C_ONE  = npsnap_pkg::coord_t'(1);
	localparam npsnap_pkg::coord_t C_NEG  = '1;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [npsnap_pkg::PADDR_W-1:0] paddr;
	logic [npsnap_pkg::PDATA_W-1:0] pwdata;
	logic [npsnap_pkg::PDATA_W-1:0] prdata;
	logic pready;

	npsnap_cmd_if cmd_ch ();
	npsnap_res_if res_ch ();

	nearest_point_snap_3d u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	npsnap_pkg::coord_t pt_x [npsnap_pkg::MAX_POINTS];
	npsnap_pkg::coord_t pt_y [npsnap_pkg::MAX_POINTS];
	npsnap_pkg::coord_t pt_z [npsnap_pkg::MAX_POINTS];
	bit pt_loaded [npsnap_pkg::MAX_POINTS];
	logic [npsnap_pkg::COUNT_W-1:0] cfg_count = '0;
	npsnap_pkg::dist_t run_max = '0;
	npsnap_pkg::res_word_t pending_snaps [$];

	int src_mode = SRC_STREAM;
	int sink_mode = SINK_READY;
	int grid_bias = 0;
	int burst_left = 0;
	int sink_hold = 0;
	int idle_cycles = 0;
	int n_errors = 0;
	int n_checked = 0;
	int n_loads = 0;
	int n_queries = 0;
	int n_empty = 0;
	int n_settings = 0;

	function automatic npsnap_pkg::dist_t sq_gap(input npsnap_pkg::coord_t a,
			input npsnap_pkg::coord_t b);
		longint g;
		g = longint'(a) - longint'(b);
		return npsnap_pkg::dist_t'(g * g);
	endfunction

	// With 24-bit coordinates the sum of three squared gaps stays below 2^50,
	// so the saturation of the distance never comes into play.
	function automatic npsnap_pkg::res_word_t predict_snap(input npsnap_pkg::cmd_word_t q);
		npsnap_pkg::res_word_t r;
		int n;
		int i;
		int best;
		longint d;
		longint best_d;
		r = '0;
		best = -1;
		best_d = 0;
		if (q.batch_start)
			run_max = '0;
		n = (cfg_count > npsnap_pkg::MAX_POINTS) ? npsnap_pkg::MAX_POINTS : int'(cfg_count);
		for (i = 0; i < n; i++) begin
			d = longint'(sq_gap(q.coord_x, pt_x[i])) + longint'(sq_gap(q.coord_y, pt_y[i]))
				+ longint'(sq_gap(q.coord_z, pt_z[i]));
			if (best < 0 || d < best_d) begin
				best = i;
				best_d = d;
			end
		end
		if (best >= 0) begin
			if (npsnap_pkg::dist_t'(best_d) > run_max)
				run_max = npsnap_pkg::dist_t'(best_d);
			r.found = 1'b1;
			r.nearest_index = npsnap_pkg::INDEX_W'(best);
			r.snap_x = pt_x[best];
			r.snap_y = pt_y[best];
			r.snap_z = pt_z[best];
			r.dist_squared = npsnap_pkg::dist_t'(best_d);
		end
		r.max_move_squared = run_max;
		return r;
	endfunction

	function automatic npsnap_pkg::coord_t pick_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 4))
				0: return C_MIN;
				1: return C_MAX;
				2: return C_ZERO;
				3: return C_NEG;
				default: return C_ONE;
			endcase
		end
		if (r <= 2 + 4 * grid_bias)
			return npsnap_pkg::coord_t'((int'($urandom_range(0, 8)) - 4) * 4096);
		return npsnap_pkg::coord_t'($urandom());
	endfunction

	function automatic npsnap_pkg::cmd_word_t make_word(input npsnap_pkg::op_t op,
			input int slot, input npsnap_pkg::coord_t x, input npsnap_pkg::coord_t y,
			input npsnap_pkg::coord_t z, input bit batch);
		npsnap_pkg::cmd_word_t w;
		w.opcode = op;
		w.slot = npsnap_pkg::SLOT_W'(slot);
		w.coord_x = x;
		w.coord_y = y;
		w.coord_z = z;
		w.batch_start = batch;
		return w;
	endfunction

	task automatic compare_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endtask

	task automatic send_word(input npsnap_pkg::cmd_word_t w);
		npsnap_pkg::res_word_t snap;
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= w;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		if (w.opcode == npsnap_pkg::OP_LOAD) begin
			pt_x[w.slot] = w.coord_x;
			pt_y[w.slot] = w.coord_y;
			pt_z[w.slot] = w.coord_z;
			pt_loaded[w.slot] = 1'b1;
			n_loads++;
		end else begin
			snap = predict_snap(w);
			pending_snaps.push_back(snap);
			n_queries++;
			if (!snap.found)
				n_empty++;
		end
		if (src_mode == SRC_BURSTY) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				cmd_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				burst_left = $urandom_range(0, 10);
			end
		end
	endtask

	task automatic send_queries(input int count);
		int i;
		for (i = 0; i < count; i++)
			send_word(make_word(npsnap_pkg::OP_QUERY, $urandom_range(0, 1023), pick_coord(),
				pick_coord(), pick_coord(), i == 0 || $urandom_range(0, 4) == 0));
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (pending_snaps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input npsnap_pkg::reg_idx_t idx,
			input logic [npsnap_pkg::PDATA_W-1:0] wdata,
			output logic [npsnap_pkg::PDATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= npsnap_pkg::PADDR_W'(4 * int'(idx));
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_point_count();
		logic [npsnap_pkg::PDATA_W-1:0] rd;
		apb_access(1'b0, npsnap_pkg::REG_POINT_COUNT, '0, rd);
		compare_field("point_count", {53'd0, cfg_count}, {32'd0, rd});
	endtask

	task automatic fill_missing(input int value);
		int i;
		for (i = 0; i < value && i < npsnap_pkg::MAX_POINTS; i++)
			if (!pt_loaded[i])
				send_word(make_word(npsnap_pkg::OP_LOAD, i, pick_coord(), pick_coord(),
					pick_coord(), $urandom_range(0, 1)));
	endtask

	// Every entry that the new count will search is loaded before the write.
	task automatic set_point_count(input int value);
		logic [npsnap_pkg::PDATA_W-1:0] rd;
		fill_missing(value);
		drain();
		apb_access(1'b1, npsnap_pkg::REG_POINT_COUNT,
			npsnap_pkg::PDATA_W'(($urandom() << npsnap_pkg::COUNT_W) | value), rd);
		cfg_count = npsnap_pkg::COUNT_W'(value);
		n_settings++;
		check_point_count();
	endtask

	task automatic test_reset_state();
		src_mode = SRC_STREAM;
		sink_mode = SINK_READY;
		check_point_count();
		send_word(make_word(npsnap_pkg::OP_QUERY, 1023, C_MAX, C_MIN, C_ZERO, 1'b0));
		send_word(make_word(npsnap_pkg::OP_QUERY, 0, C_MIN, C_MAX, C_NEG, 1'b1));
	endtask

	task automatic test_extremes();
		send_word(make_word(npsnap_pkg::OP_LOAD, 0, C_MAX, C_MAX, C_MAX, 1'b1));
		send_word(make_word(npsnap_pkg::OP_LOAD, 1, C_MIN, C_MIN, C_MIN, 1'b0));
		send_word(make_word(npsnap_pkg::OP_LOAD, 2, C_ZERO, C_ZERO, C_ZERO, 1'b0));
		send_word(make_word(npsnap_pkg::OP_LOAD, 3, C_ZERO, C_ZERO, C_ZERO, 1'b1));
		send_word(make_word(npsnap_pkg::OP_LOAD, 1023, C_MIN, C_MAX, C_ZERO, 1'b0));
		set_point_count(1);
		send_word(make_word(npsnap_pkg::OP_QUERY, 0, C_MIN, C_MIN, C_MIN, 1'b1));
		send_word(make_word(npsnap_pkg::OP_QUERY, 1023, C_MAX, C_MAX, C_MAX, 1'b0));
		set_point_count(0);
		send_word(make_word(npsnap_pkg::OP_QUERY, 5, C_ONE, C_NEG, C_ZERO, 1'b0));
		send_word(make_word(npsnap_pkg::OP_QUERY, 6, C_ONE, C_NEG, C_ZERO, 1'b1));
		set_point_count(4);
		send_word(make_word(npsnap_pkg::OP_QUERY, 0, C_ZERO, C_ZERO, C_ZERO, 1'b1));
		send_word(make_word(npsnap_pkg::OP_QUERY, 0, C_NEG, C_NEG, C_NEG, 1'b0));
		send_word(make_word(npsnap_pkg::OP_QUERY, 1023, C_MIN, C_MIN, C_MIN, 1'b0));
		send_word(make_word(npsnap_pkg::OP_QUERY, 512, C_MAX, C_MIN, C_ZERO, 1'b0));
	endtask

	task automatic test_register_decode();
		logic [npsnap_pkg::PDATA_W-1:0] rd;
		drain();
		apb_access(1'b1, npsnap_pkg::REG_UNUSED, $urandom(), rd);
		check_point_count();
	endtask

	task automatic test_random_mix(input int n_items, input int count_hi);
		int count;
		int i;
		int slot;
		count = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, count_hi);
		src_mode = $urandom_range(SRC_STREAM, SRC_BURSTY);
		sink_mode = $urandom_range(SINK_READY, SINK_HEAVY);
		grid_bias = $urandom_range(0, 1);
		set_point_count(count);
		for (i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 99) < 35) begin
				if (count > 0 && $urandom_range(0, 2) != 0)
					slot = $urandom_range(0, count - 1);
				else
					slot = $urandom_range(0, 1023);
				send_word(make_word(npsnap_pkg::OP_LOAD, slot, pick_coord(), pick_coord(),
					pick_coord(), $urandom_range(0, 1)));
			end else begin
				send_word(make_word(npsnap_pkg::OP_QUERY, $urandom_range(0, 1023),
					pick_coord(), pick_coord(), pick_coord(), $urandom_range(0, 6) == 0));
			end
		end
	endtask

	task automatic test_full_store();
		src_mode = SRC_BURSTY;
		sink_mode = SINK_LIGHT;
		grid_bias = 0;
		set_point_count(npsnap_pkg::MAX_POINTS);
		send_queries(5);
		set_point_count((1 << npsnap_pkg::COUNT_W) - 1);
		send_queries(4);
		set_point_count(npsnap_pkg::MAX_POINTS + 1);
		send_queries(2);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			sink_hold = 0;
		end else if (sink_hold > 0) begin
			sink_hold--;
			res_ch.ready <= 1'b0;
		end else begin
			if (sink_mode == SINK_LIGHT && $urandom_range(0, 7) == 0)
				sink_hold = $urandom_range(1, 3);
			else if (sink_mode == SINK_HEAVY && $urandom_range(0, 2) == 0)
				sink_hold = $urandom_range(2, 12);
			res_ch.ready <= (sink_hold == 0);
		end
	end

	always @(posedge clk) begin
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_snaps.size() == 0) begin
				$error("result word arrived with no query waiting");
				n_errors++;
			end else begin
				compare_field("found", pending_snaps[0].found, res_ch.data.found);
				compare_field("nearest_index", pending_snaps[0].nearest_index,
					res_ch.data.nearest_index);
				compare_field("snap_x", pending_snaps[0].snap_x, res_ch.data.snap_x);
				compare_field("snap_y", pending_snaps[0].snap_y, res_ch.data.snap_y);
				compare_field("snap_z", pending_snaps[0].snap_z, res_ch.data.snap_z);
				compare_field("dist_squared", pending_snaps[0].dist_squared,
					res_ch.data.dist_squared);
				compare_field("max_move_squared", pending_snaps[0].max_move_squared,
					res_ch.data.max_move_squared);
				void'(pending_snaps.pop_front());
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (psel && penable)) begin
			idle_cycles = 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_extremes();
		test_register_decode();
		for (int ph = 0; ph < 9; ph++)
			test_random_mix(60, (ph == 4) ? 300 : 48);
		test_full_store();
		drain();
		repeat (END_CYCLES) @(posedge clk);
		$display("Sent %0d point loads and %0d queries (%0d with nothing to search) over %0d %s",
			n_loads, n_queries, n_empty, n_settings, "point count settings.");
		$display("Checked %0d snap results; %0d mismatches found.", n_checked, n_errors);
		if (n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: nearest_point_snap_3d.f
rtl/core/npsnap_pkg.sv
rtl/core/npsnap_if.sv
rtl/core/nearest_point_snap_3d.sv
dv/tb_top.sv
